[rtl/ssa_pkg.sv]
// ----------------------------------------------------------------------------
// Sample statistics accumulator package
// Default sizes, field widths and operation codes shared by the block.
// ----------------------------------------------------------------------------
package ssa_pkg;

   localparam int COUNT_BITS  = 24;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 4;

   localparam int OPERATION_W   = 2;
   localparam int AMPLITUDE_W   = 16;
   localparam int COUNT_FIELD_W = 24;
   localparam int MEAN_FIELD_W  = 20;
   localparam int SIGMA_FIELD_W = 20;
   localparam int SMALLEST_W    = 16;
   localparam int LARGEST_W     = 16;
   localparam int RSP_DATA_W    = 96;

   typedef logic [OPERATION_W-1:0] operation_type;

   localparam operation_type OP_SAMPLE = 2'd0;
   localparam operation_type OP_CLEAR  = 2'd1;
   localparam operation_type OP_STOP   = 2'd2;
   localparam operation_type OP_REPORT = 2'd3;

endpackage

[rtl/sample_statistics_accumulator.sv]
// ----------------------------------------------------------------------------
// Sample statistics accumulator
// Keeps count, sum, sum of squares, minimum and maximum of pulse amplitudes
// and reports count, min, max, mean and sample sigma on request.
//
//   Channel | Dir | Handshake             | Payload
//   req     | in  | req_tvalid/req_tready | tdata: amplitude; tuser: operation
//   rsp     | out | rsp_tvalid/rsp_tready | tdata: count, mean, sigma, min, max
//
// Sample, clear and stop update the statistics registers; back-to-back transfers are taken.
// Report runs on one shared adder/subtractor, one step per cycle: mean division,
// the two products, the difference, the denominator product, variance division
// and square root, in that order; the input is held until the result moves to
// the output register. With fewer than two samples the steps are skipped.
// req_tready is low while a report is computing or its result waits for the
// output register. Reset is synchronous and clears all statistics to zero.
// ----------------------------------------------------------------------------
module sample_statistics_accumulator #(
   parameter int COUNT_BITS  = ssa_pkg::COUNT_BITS,
   parameter int SAMPLE_BITS = ssa_pkg::SAMPLE_BITS,
   parameter int FRAC_BITS   = ssa_pkg::FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssa_pkg::AMPLITUDE_W-1:0]   req_tdata,  // [15:0] amplitude
   input  logic [ssa_pkg::OPERATION_W-1:0]   req_tuser,  // [1:0] operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] sample_count, [43:24] mean_value, [63:44] std_deviation,
   // [79:64] smallest, [95:80] largest
   output logic [ssa_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_W  = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int R_W   = SAMPLE_BITS + FRAC_BITS;
   localparam int CW    = (COUNT_BITS > ssa_pkg::COUNT_FIELD_W) ?
                          COUNT_BITS : ssa_pkg::COUNT_FIELD_W;
   localparam int MW    = (R_W > ssa_pkg::MEAN_FIELD_W) ? R_W : ssa_pkg::MEAN_FIELD_W;
   localparam int SW    = (R_W > ssa_pkg::SIGMA_FIELD_W) ? R_W : ssa_pkg::SIGMA_FIELD_W;

   logic                    collecting_ff, collecting_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [SAMPLE_BITS-1:0]  min_ff, min_in;
   logic [SAMPLE_BITS-1:0]  max_ff, max_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ssa_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   ssa_pkg::operation_type  op;
   logic [SAMPLE_BITS-1:0]  amp;
   logic [2*SAMPLE_BITS-1:0] amp_sq;
   logic                    accept, start, busy, res_valid, res_ready;
   logic [R_W-1:0]          mean_raw, sigma_raw;
   logic [CW-1:0]           count_ext;
   logic [MW-1:0]           mean_ext;
   logic [SW-1:0]           sigma_ext;
   logic [ssa_pkg::COUNT_FIELD_W-1:0] count_sat;
   logic [ssa_pkg::MEAN_FIELD_W-1:0]  mean_sat;
   logic [ssa_pkg::SIGMA_FIELD_W-1:0] sigma_sat;

   assign op     = req_tuser;
   assign amp    = req_tdata[SAMPLE_BITS-1:0];
   assign amp_sq = amp * amp;
   assign accept = req_tvalid && req_tready;
   assign start  = accept && (op == ssa_pkg::OP_REPORT);
   assign req_tready = !busy;

   ssa_seq #(
      .COUNT_BITS (COUNT_BITS),
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .count        (count_ff),
      .sum          (sum_ff),
      .sumsq        (sumsq_ff),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .mean_value   (mean_raw),
      .std_deviation(sigma_raw)
   );

   always_comb begin
      collecting_in = collecting_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      sumsq_in      = sumsq_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      if (accept) begin
         case (op)
            ssa_pkg::OP_SAMPLE: begin
               // drop samples while stopped or once the count is full
               if (collecting_ff && (count_ff != '1)) begin
                  count_in = count_ff + COUNT_BITS'(1);
                  sum_in   = sum_ff + SUM_W'(amp);
                  sumsq_in = sumsq_ff + SQ_W'(amp_sq);
                  min_in   = (amp < min_ff) ? amp : min_ff;
                  max_in   = (amp > max_ff) ? amp : max_ff;
               end
            end
            ssa_pkg::OP_CLEAR: begin
               count_in      = '0;
               sum_in        = '0;
               sumsq_in      = '0;
               min_in        = '1;
               max_in        = '0;
               collecting_in = 1'b1;
            end
            ssa_pkg::OP_STOP: begin
               collecting_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // saturate count, mean and sigma to their fields
   assign count_ext = CW'(count_ff);
   assign mean_ext  = MW'(mean_raw);
   assign sigma_ext = SW'(sigma_raw);
   assign count_sat = (count_ext > CW'({ssa_pkg::COUNT_FIELD_W{1'b1}})) ?
                      '1 : count_ext[ssa_pkg::COUNT_FIELD_W-1:0];
   assign mean_sat  = (mean_ext > MW'({ssa_pkg::MEAN_FIELD_W{1'b1}})) ?
                      '1 : mean_ext[ssa_pkg::MEAN_FIELD_W-1:0];
   assign sigma_sat = (sigma_ext > SW'({ssa_pkg::SIGMA_FIELD_W{1'b1}})) ?
                      '1 : sigma_ext[ssa_pkg::SIGMA_FIELD_W-1:0];

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {ssa_pkg::LARGEST_W'(max_ff), ssa_pkg::SMALLEST_W'(min_ff),
                         sigma_sat, mean_sat, count_sat};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         sum_ff        <= '0;
         sumsq_ff      <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         sumsq_ff      <= sumsq_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_report_blocks: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("input still ready after report transfer");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum above maximum with samples present");

   a_stopped_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (op == ssa_pkg::OP_SAMPLE) && !collecting_ff |=> $stable(count_ff))
      else $error("sample counted while stopped");

endmodule

[rtl/ssa_alu.sv]
// ----------------------------------------------------------------------------
// Shared adder / subtractor
// One wide add or subtract; carry out is set on subtract when a >= b.
// ----------------------------------------------------------------------------
module ssa_alu #(
   parameter int WIDTH = 80
) (
   input  logic [WIDTH-1:0] opa,
   input  logic [WIDTH-1:0] opb,
   input  logic             sub_en,
   output logic [WIDTH-1:0] sum_out,
   output logic             carry_out
);

   logic [WIDTH:0] total;

   assign total = {1'b0, opa} + {1'b0, opb ^ {WIDTH{sub_en}}} + (WIDTH + 1)'(sub_en);
   assign sum_out   = total[WIDTH-1:0];
   assign carry_out = total[WIDTH];

endmodule

[rtl/ssa_seq.sv]
// ----------------------------------------------------------------------------
// Report sequencer
// Computes mean and sample sigma with one shared adder: restoring division
// for the mean, shift-add products, restoring division for the variance and
// a digit-by-digit square root.
// ----------------------------------------------------------------------------
module ssa_seq #(
   parameter int COUNT_BITS  = ssa_pkg::COUNT_BITS,
   parameter int SAMPLE_BITS = ssa_pkg::SAMPLE_BITS,
   parameter int FRAC_BITS   = ssa_pkg::FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [COUNT_BITS-1:0]                 count,
   input  logic [SAMPLE_BITS+COUNT_BITS-1:0]     sum,
   input  logic [2*SAMPLE_BITS+COUNT_BITS-1:0]   sumsq,
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]      mean_value,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]      std_deviation
);

   localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
   localparam int PROD_W = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
   localparam int DEN_W  = 2 * COUNT_BITS;
   localparam int Q_W    = 2 * SAMPLE_BITS + 2 * FRAC_BITS;
   localparam int NUM_W  = PROD_W + 2 * FRAC_BITS;
   localparam int MQ_W   = SAMPLE_BITS + FRAC_BITS;
   localparam int MNUM_W = SUM_W + FRAC_BITS;
   localparam int R_W    = SAMPLE_BITS + FRAC_BITS;
   localparam int MOP_W  = SUM_W;
   localparam int STEP_W = $clog2((SUM_W > Q_W) ? SUM_W : Q_W);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MEAN    = 4'd1;
   localparam logic [3:0] S_MUL_NSQ = 4'd2;
   localparam logic [3:0] S_MUL_SSQ = 4'd3;
   localparam logic [3:0] S_DIFF    = 4'd4;
   localparam logic [3:0] S_MUL_DEN = 4'd5;
   localparam logic [3:0] S_VAR_DIV = 4'd6;
   localparam logic [3:0] S_SQRT    = 4'd7;
   localparam logic [3:0] S_DONE    = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] nsq_ff, nsq_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [MOP_W-1:0]  mop_ff, mop_in;
   logic [MQ_W-1:0]   mean_ff, mean_in;
   logic [R_W-1:0]    root_ff, root_in;

   logic [PROD_W-1:0] alu_a, alu_b, alu_res, mul_operand;
   logic              alu_sub, alu_carry, last;
   logic [MNUM_W-1:0] mean_num;
   logic [NUM_W-1:0]  var_num;
   logic [DEN_W:0]    div_trial;
   logic [R_W+2:0]    sq_rem;

   ssa_alu #(
      .WIDTH(PROD_W)
   ) u_alu (
      .opa      (alu_a),
      .opb      (alu_b),
      .sub_en   (alu_sub),
      .sum_out  (alu_res),
      .carry_out(alu_carry)
   );

   assign last      = (cnt_ff == '0);
   assign mean_num  = MNUM_W'(sum) << FRAC_BITS;
   assign var_num   = NUM_W'(nsq_ff) << (2 * FRAC_BITS);
   assign div_trial = {acc_ff[DEN_W-1:0], quo_ff[Q_W-1]};
   assign sq_rem    = {acc_ff[R_W:0], quo_ff[Q_W-1 -: 2]};

   always_comb begin
      case (state_ff)
         S_MUL_NSQ: mul_operand = PROD_W'(sumsq);
         S_MUL_SSQ: mul_operand = PROD_W'(sum);
         S_MUL_DEN: mul_operand = PROD_W'(count);
         default:   mul_operand = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      nsq_in   = nsq_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      mop_in   = mop_ff;
      mean_in  = mean_ff;
      root_in  = root_ff;
      alu_a    = '0;
      alu_b    = '0;
      alu_sub  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (count < COUNT_BITS'(2)) begin
                  mean_in  = '0;
                  root_in  = '0;
                  state_in = S_DONE;
               end else begin
                  // quotient fits MQ_W bits, so the bits above it start as remainder
                  den_in   = DEN_W'(count);
                  acc_in   = PROD_W'(mean_num[MNUM_W-1:MQ_W]);
                  quo_in   = Q_W'(mean_num[MQ_W-1:0]) << (Q_W - MQ_W);
                  cnt_in   = STEP_W'(MQ_W - 1);
                  state_in = S_MEAN;
               end
            end
         end
         S_MEAN, S_VAR_DIV: begin
            alu_a   = PROD_W'(div_trial);
            alu_b   = PROD_W'(den_ff);
            alu_sub = 1'b1;
            acc_in  = PROD_W'(alu_carry ? alu_res[DEN_W-1:0] : div_trial[DEN_W-1:0]);
            quo_in  = {quo_ff[Q_W-2:0], alu_carry};
            cnt_in  = cnt_ff - STEP_W'(1);
            if (last) begin
               acc_in = '0;
               if (state_ff == S_MEAN) begin
                  mean_in  = quo_in[MQ_W-1:0];
                  mop_in   = MOP_W'(count) << (MOP_W - COUNT_BITS);
                  cnt_in   = STEP_W'(COUNT_BITS - 1);
                  state_in = S_MUL_NSQ;
               end else begin
                  root_in  = '0;
                  cnt_in   = STEP_W'(R_W - 1);
                  state_in = S_SQRT;
               end
            end
         end
         S_MUL_NSQ, S_MUL_SSQ, S_MUL_DEN: begin
            alu_a  = acc_ff << 1;
            alu_b  = mop_ff[MOP_W-1] ? mul_operand : '0;
            acc_in = alu_res;
            mop_in = mop_ff << 1;
            cnt_in = cnt_ff - STEP_W'(1);
            if (last) begin
               case (state_ff)
                  S_MUL_NSQ: begin
                     nsq_in   = alu_res;
                     acc_in   = '0;
                     mop_in   = sum;
                     cnt_in   = STEP_W'(SUM_W - 1);
                     state_in = S_MUL_SSQ;
                  end
                  S_MUL_SSQ: begin
                     state_in = S_DIFF;
                  end
                  default: begin
                     den_in   = alu_res[DEN_W-1:0];
                     acc_in   = PROD_W'(var_num[NUM_W-1:Q_W]);
                     quo_in   = var_num[Q_W-1:0];
                     cnt_in   = STEP_W'(Q_W - 1);
                     state_in = S_VAR_DIV;
                  end
               endcase
            end
         end
         S_DIFF: begin
            alu_a   = nsq_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
            if (alu_carry) begin
               nsq_in   = alu_res;
               acc_in   = '0;
               mop_in   = MOP_W'(count - COUNT_BITS'(1)) << (MOP_W - COUNT_BITS);
               cnt_in   = STEP_W'(COUNT_BITS - 1);
               state_in = S_MUL_DEN;
            end else begin
               // negative numerator: report zero sigma
               root_in  = '0;
               state_in = S_DONE;
            end
         end
         S_SQRT: begin
            alu_a   = PROD_W'(sq_rem);
            alu_b   = PROD_W'({root_ff, 2'b01});
            alu_sub = 1'b1;
            acc_in  = PROD_W'(alu_carry ? alu_res[R_W+1:0] : sq_rem[R_W+1:0]);
            root_in = {root_ff[R_W-2:0], alu_carry};
            quo_in  = quo_ff << 2;
            cnt_in  = cnt_ff - STEP_W'(1);
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      nsq_ff  <= nsq_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      mop_ff  <= mop_in;
      mean_ff <= mean_in;
      root_ff <= root_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign res_valid     = (state_ff == S_DONE);
   assign mean_value    = mean_ff;
   assign std_deviation = root_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("report started while sequencer busy");

   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && res_ready |=> (state_ff == S_IDLE))
      else $error("result transfer did not release sequencer");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VAR_DIV) |-> (acc_ff[DEN_W-1:0] < den_ff))
      else $error("division remainder not below divisor");

endmodule
